@@ hdl/bsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

  // Pool geometry
  localparam int MAX_SLOTS = 256;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int MAP_WORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W     = WIDX_W + BIT_W;
  localparam int CAP_W     = $clog2(MAX_SLOTS + 1);

  // Field widths
  localparam int SLOT_CNT_W   = 9;
  localparam int SLOT_BYTES_W = 16;
  localparam int ADDR_W       = 32;
  localparam int COUNT_W      = 9;
  localparam int STATUS_W     = 3;
  localparam int ACTION_W     = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int PROD_W       = IDX_W + SLOT_BYTES_W;

  localparam logic [WORD_W-1:0]       WORD_ONES      = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0]      COUNT_MAX      = '1;
  localparam logic [SLOT_CNT_W-1:0]   RST_SLOT_COUNT = 9'd256;
  localparam logic [SLOT_BYTES_W-1:0] RST_SLOT_BYTES = 16'd16;
  localparam logic [ADDR_W-1:0]       RST_BASE       = 32'd0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC     = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_FREED     = 3'd2,
    ST_NULL      = 3'd3,
    ST_RANGE     = 3'd4,
    ST_MISALIGN  = 3'd5,
    ST_DOUBLE    = 3'd6,
    ST_INIT      = 3'd7
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_COUNT   = 2'd0,
    CFG_SLOT_BYTES   = 2'd1,
    CFG_BASE_ADDRESS = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MUL,
    S_ADD,
    S_DIV,
    S_FREE_CHK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [SLOT_CNT_W-1:0]   slot_count;
    logic [SLOT_BYTES_W-1:0] slot_bytes;
    logic [ADDR_W-1:0]       base_address;
  } cfg_t;

  typedef struct packed {
    logic                    start;
    logic [ADDR_W-1:0]       dividend;
    logic [SLOT_BYTES_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [ADDR_W-1:0]       quotient;
    logic [SLOT_BYTES_W-1:0] remainder;
  } div_rsp_t;

  // Slot count clamped to what the map can hold
  function automatic logic [CAP_W-1:0] live_cap(logic [SLOT_CNT_W-1:0] sc);
    logic [CAP_W-1:0] r;
    if (int'(sc) > MAX_SLOTS) begin
      r = CAP_W'(MAX_SLOTS);
    end else begin
      r = CAP_W'(sc);
    end
    return r;
  endfunction

  localparam logic [CAP_W-1:0] RST_CAP = live_cap(RST_SLOT_COUNT);

  // Map word w after init with cap free slots
  function automatic logic [WORD_W-1:0] init_word(logic [CAP_W-1:0] cap,
                                                  logic [WIDX_W-1:0] w);
    int lo;
    int c;
    logic [WORD_W-1:0] r;
    lo = int'(w) * WORD_W;
    c  = int'(cap);
    if (c >= lo + WORD_W) begin
      r = WORD_ONES;
    end else if (c > lo) begin
      r = ~(WORD_ONES << BIT_W'(c - lo));
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_bit(logic [WORD_W-1:0] m);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (m[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/bsa_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bsa_req_if;
  logic                          valid;
  logic                          ready;
  logic [bsa_pkg::ACTION_W-1:0]  action;
  logic [bsa_pkg::ADDR_W-1:0]    release_address;

  modport source (output valid, output action, output release_address, input ready);
  modport sink   (input valid, input action, input release_address, output ready);
endinterface

`default_nettype wire

@@ hdl/bsa_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bsa_pkg::STATUS_W-1:0]  status;
  logic [bsa_pkg::ADDR_W-1:0]    slot_address;
  logic [bsa_pkg::COUNT_W-1:0]   in_use;

  modport source (output valid, output status, output slot_address, output in_use,
                  input ready);
  modport sink   (input valid, input status, input slot_address, input in_use,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/bsa_map_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsa_map_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/bsa_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsa_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bsa_pkg::div_req_t req_i,
  output bsa_pkg::div_rsp_t      rsp_o
);

  localparam int DW = bsa_pkg::ADDR_W;
  localparam int RW = bsa_pkg::SLOT_BYTES_W;
  localparam int CW = $clog2(DW);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd_q;
  logic [DW-1:0] quo_q;
  logic [RW-1:0] rem_q;
  logic [RW-1:0] dsr_q;

  logic [RW:0]   shifted;
  logic [RW:0]   diff;
  logic          fits;

  // One restoring step per cycle, quotient bit enters from the right
  always_comb begin
    shifted = {rem_q, dvd_q[DW-1]};
    diff    = shifted - {1'b0, dsr_q};
    fits    = shifted >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      rem_q <= fits ? diff[RW-1:0] : shifted[RW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

@@ hdl/bsa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsa_ctrl (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire bsa_pkg::cfg_t                       cfg_i,
  bsa_req_if.sink                                  req_i,
  bsa_rsp_if.source                                rsp_o,
  output logic                                     ram_we_o,
  output logic [bsa_pkg::WIDX_W-1:0]               ram_waddr_o,
  output logic [bsa_pkg::WORD_W-1:0]               ram_wdata_o,
  output logic                                     ram_re_o,
  output logic [bsa_pkg::WIDX_W-1:0]               ram_raddr_o,
  input  wire logic [bsa_pkg::WORD_W-1:0]          ram_rdata_i,
  output bsa_pkg::div_req_t                        div_req_o,
  input  wire bsa_pkg::div_rsp_t                   div_rsp_i
);

  localparam int WIDX_W  = bsa_pkg::WIDX_W;
  localparam int IDX_W   = bsa_pkg::IDX_W;
  localparam int CAP_W   = bsa_pkg::CAP_W;
  localparam int COUNT_W = bsa_pkg::COUNT_W;
  localparam int WORD_W  = bsa_pkg::WORD_W;
  localparam int BIT_W   = bsa_pkg::BIT_W;
  localparam int ADDR_W  = bsa_pkg::ADDR_W;
  localparam int PROD_W  = bsa_pkg::PROD_W;

  bsa_pkg::state_e  state_q, state_d;
  logic [WIDX_W-1:0] wcnt_q;
  logic [CAP_W-1:0]  sweep_cap_q;
  logic              sweep_init_q;
  logic [COUNT_W-1:0] used_q;
  logic [IDX_W-1:0]  idx_q;
  logic [PROD_W-1:0] prod_q;
  bsa_pkg::status_e  res_status_q;
  logic [ADDR_W-1:0] res_addr_q;
  logic              out_valid_q;
  bsa_pkg::status_e  out_status_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [COUNT_W-1:0] out_in_use_q;

  logic [CAP_W-1:0]  cap;
  int                scan_words;
  bsa_pkg::action_e  act;
  logic              accept;
  logic              sweep_last;
  logic              word_busy;
  logic [BIT_W-1:0]  low_b;
  logic [IDX_W-1:0]  scan_idx;
  logic              scan_over;
  logic              scan_last;
  logic              free_early;
  logic              div_bad;
  logic              bit_free;
  logic              emit_go;

  always_comb begin
    cap        = bsa_pkg::live_cap(cfg_i.slot_count);
    scan_words = (int'(cap) + WORD_W - 1) / WORD_W;
    act        = bsa_pkg::action_e'(req_i.action);
    accept     = req_i.valid && req_i.ready;
    sweep_last = wcnt_q == WIDX_W'(bsa_pkg::MAP_WORDS - 1);
    word_busy  = ram_rdata_i == '0;
    low_b      = bsa_pkg::lowest_bit(ram_rdata_i);
    scan_idx   = {wcnt_q, low_b};
    scan_over  = int'(scan_idx) >= int'(cap);
    scan_last  = int'(wcnt_q) + 1 >= scan_words;
    free_early = (req_i.release_address == '0) || (cfg_i.slot_bytes == '0);
    div_bad    = (div_rsp_i.quotient >= ADDR_W'(cap)) || (div_rsp_i.remainder != '0);
    bit_free   = ram_rdata_i[idx_q[BIT_W-1:0]];
    emit_go    = (state_q == bsa_pkg::S_EMIT) && (!out_valid_q || rsp_o.ready);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsa_pkg::S_SWEEP: begin
        if (sweep_last) state_d = sweep_init_q ? bsa_pkg::S_EMIT : bsa_pkg::S_IDLE;
      end
      bsa_pkg::S_IDLE: begin
        if (accept) begin
          unique case (act)
            bsa_pkg::ACT_INIT:  state_d = bsa_pkg::S_SWEEP;
            bsa_pkg::ACT_ALLOC: state_d = (cap == '0) ? bsa_pkg::S_EMIT : bsa_pkg::S_SCAN_RD;
            bsa_pkg::ACT_FREE:  state_d = free_early ? bsa_pkg::S_EMIT : bsa_pkg::S_DIV;
            default:            state_d = bsa_pkg::S_IDLE;
          endcase
        end
      end
      bsa_pkg::S_SCAN_RD: state_d = bsa_pkg::S_SCAN_CHK;
      bsa_pkg::S_SCAN_CHK: begin
        if (!word_busy) begin
          state_d = scan_over ? bsa_pkg::S_EMIT : bsa_pkg::S_MUL;
        end else begin
          state_d = scan_last ? bsa_pkg::S_EMIT : bsa_pkg::S_SCAN_RD;
        end
      end
      bsa_pkg::S_MUL: state_d = bsa_pkg::S_ADD;
      bsa_pkg::S_ADD: state_d = bsa_pkg::S_EMIT;
      bsa_pkg::S_DIV: begin
        if (div_rsp_i.done) state_d = div_bad ? bsa_pkg::S_EMIT : bsa_pkg::S_FREE_CHK;
      end
      bsa_pkg::S_FREE_CHK: state_d = bsa_pkg::S_EMIT;
      bsa_pkg::S_EMIT: begin
        if (emit_go) state_d = bsa_pkg::S_IDLE;
      end
      default: state_d = bsa_pkg::S_IDLE;
    endcase
  end

  // Outputs toward the map memory, divider and request channel
  always_comb begin
    req_i.ready        = state_q == bsa_pkg::S_IDLE;
    ram_we_o           = 1'b0;
    ram_waddr_o        = wcnt_q;
    ram_wdata_o        = '0;
    ram_re_o           = 1'b0;
    ram_raddr_o        = wcnt_q;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = req_i.release_address - cfg_i.base_address;
    div_req_o.divisor  = cfg_i.slot_bytes;
    unique case (state_q)
      bsa_pkg::S_SWEEP: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = bsa_pkg::init_word(sweep_cap_q, wcnt_q);
      end
      bsa_pkg::S_IDLE: begin
        div_req_o.start = accept && (act == bsa_pkg::ACT_FREE) && !free_early;
      end
      bsa_pkg::S_SCAN_RD: ram_re_o = 1'b1;
      bsa_pkg::S_SCAN_CHK: begin
        // claim the lowest free bit
        ram_we_o    = !word_busy && !scan_over;
        ram_wdata_o = ram_rdata_i & ~(WORD_W'(1) << low_b);
      end
      bsa_pkg::S_DIV: begin
        ram_re_o    = div_rsp_i.done;
        ram_raddr_o = div_rsp_i.quotient[IDX_W-1:BIT_W];
      end
      bsa_pkg::S_FREE_CHK: begin
        ram_we_o    = !bit_free;
        ram_waddr_o = idx_q[IDX_W-1:BIT_W];
        ram_wdata_o = ram_rdata_i | (WORD_W'(1) << idx_q[BIT_W-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bsa_pkg::S_SWEEP;
      wcnt_q       <= '0;
      sweep_cap_q  <= bsa_pkg::RST_CAP;
      sweep_init_q <= 1'b0;
      used_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        bsa_pkg::S_SWEEP: begin
          wcnt_q <= sweep_last ? '0 : wcnt_q + WIDX_W'(1);
          if (sweep_last) used_q <= '0;
        end
        bsa_pkg::S_IDLE: begin
          wcnt_q <= '0;
          if (accept && act == bsa_pkg::ACT_INIT) begin
            sweep_cap_q  <= cap;
            sweep_init_q <= 1'b1;
          end
        end
        bsa_pkg::S_SCAN_CHK: begin
          if (word_busy && !scan_last) wcnt_q <= wcnt_q + WIDX_W'(1);
          if (!word_busy && !scan_over && used_q != bsa_pkg::COUNT_MAX) begin
            used_q <= used_q + COUNT_W'(1);
          end
        end
        bsa_pkg::S_FREE_CHK: begin
          if (!bit_free && used_q != '0) used_q <= used_q - COUNT_W'(1);
        end
        default: ;
      endcase
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      bsa_pkg::S_SWEEP: begin
        res_status_q <= bsa_pkg::ST_INIT;
        res_addr_q   <= '0;
      end
      bsa_pkg::S_IDLE: begin
        res_addr_q <= '0;
        if (act == bsa_pkg::ACT_ALLOC) begin
          res_status_q <= bsa_pkg::ST_EXHAUSTED;
        end else if (req_i.release_address == '0) begin
          res_status_q <= bsa_pkg::ST_NULL;
        end else begin
          res_status_q <= bsa_pkg::ST_RANGE;
        end
      end
      bsa_pkg::S_SCAN_CHK: begin
        res_status_q <= bsa_pkg::ST_EXHAUSTED;
        idx_q        <= scan_idx;
      end
      bsa_pkg::S_MUL: begin
        prod_q <= PROD_W'(idx_q) * PROD_W'(cfg_i.slot_bytes);
      end
      bsa_pkg::S_ADD: begin
        res_status_q <= bsa_pkg::ST_ALLOC;
        res_addr_q   <= cfg_i.base_address + ADDR_W'(prod_q);
      end
      bsa_pkg::S_DIV: begin
        idx_q <= div_rsp_i.quotient[IDX_W-1:0];
        if (div_rsp_i.quotient >= ADDR_W'(cap)) begin
          res_status_q <= bsa_pkg::ST_RANGE;
        end else begin
          res_status_q <= bsa_pkg::ST_MISALIGN;
        end
      end
      bsa_pkg::S_FREE_CHK: begin
        res_status_q <= bit_free ? bsa_pkg::ST_DOUBLE : bsa_pkg::ST_FREED;
      end
      default: ;
    endcase
    if (emit_go) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_in_use_q <= used_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.slot_address = out_addr_q;
  assign rsp_o.in_use       = out_in_use_q;

endmodule

`default_nettype wire

@@ hdl/bitmap_slot_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Fixed-size slot allocator over a free-slot bitmap held in a small synchronous
// memory of MAP_WORDS 32-bit words (1 = free). One request is worked at a time;
// the result register lets the next request in while a response waits. After
// reset the map is filled by a pass over the MAP_WORDS words (8 at 256 slots)
// during which no request is taken. Init repeats the same fill pass. Allocate
// reads and checks the map word by word, then multiplies and adds when a slot
// is granted, and skips those steps when the scan finds no usable slot; free
// runs the radix-2 divider that turns the address offset into a slot index one
// quotient bit per cycle. Null and zero slot size frees and allocations from an
// empty pool answer without a scan or a divide.
module bitmap_slot_allocator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bsa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bsa_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  bsa_req_if.sink                               req_i,
  bsa_rsp_if.source                             rsp_o
);

  bsa_pkg::cfg_t     cfg_q;
  bsa_pkg::div_req_t div_req;
  bsa_pkg::div_rsp_t div_rsp;

  logic                         ram_we;
  logic [bsa_pkg::WIDX_W-1:0]   ram_waddr;
  logic [bsa_pkg::WORD_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [bsa_pkg::WIDX_W-1:0]   ram_raddr;
  logic [bsa_pkg::WORD_W-1:0]   ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_count   <= bsa_pkg::RST_SLOT_COUNT;
      cfg_q.slot_bytes   <= bsa_pkg::RST_SLOT_BYTES;
      cfg_q.base_address <= bsa_pkg::RST_BASE;
    end else if (cfg_we_i) begin
      unique case (bsa_pkg::cfg_idx_e'(cfg_idx_i))
        bsa_pkg::CFG_SLOT_COUNT:
          cfg_q.slot_count <= cfg_wdata_i[bsa_pkg::SLOT_CNT_W-1:0];
        bsa_pkg::CFG_SLOT_BYTES:
          cfg_q.slot_bytes <= cfg_wdata_i[bsa_pkg::SLOT_BYTES_W-1:0];
        bsa_pkg::CFG_BASE_ADDRESS:
          cfg_q.base_address <= cfg_wdata_i[bsa_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  bsa_map_ram #(
    .DEPTH (bsa_pkg::MAP_WORDS),
    .WIDTH (bsa_pkg::WORD_W),
    .AW    (bsa_pkg::WIDX_W)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bsa_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

endmodule

`default_nettype wire

@@ hdl/bsa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsa_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            rsp_valid_i,
  input wire logic                            rsp_ready_i,
  input wire logic [bsa_pkg::STATUS_W-1:0]    rsp_status_i,
  input wire logic [bsa_pkg::ADDR_W-1:0]      rsp_slot_address_i,
  input wire logic [bsa_pkg::COUNT_W-1:0]     rsp_in_use_i
);

  localparam int MAP_BITS = bsa_pkg::MAP_WORDS * bsa_pkg::WORD_W;

  // only a granted slot carries an address
  a_addr_only_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != bsa_pkg::ST_ALLOC) |-> rsp_slot_address_i == '0)
    else $error("slot address set on a non-allocate response");

  a_init_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == bsa_pkg::ST_INIT) |-> rsp_in_use_i == '0)
    else $error("init response with slots still counted");

  // the in-use count never exceeds the number of map bits
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> int'(rsp_in_use_i) <= MAP_BITS)
    else $error("in-use count exceeds map size");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_slot_address_i))
    else $error("stalled response changed");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.status),
  .rsp_slot_address_i (rsp_o.slot_address),
  .rsp_in_use_i       (rsp_o.in_use)
);

`default_nettype wire

@@ verif/slot_alloc_checker.sv @@
`timescale 1ns / 1ps

module slot_alloc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  bsa_req_if                             req_i,
  bsa_rsp_if                             rsp_i,
  output int                             mismatch_count_o,
  output int                             awaiting_o,
  output int                             checked_o
);
  import bsa_pkg::*;

  typedef struct packed {
    status_e              status;
    logic [ADDR_W-1:0]    slot_address;
    logic [COUNT_W-1:0]   in_use;
  } slot_result_t;

  // Own copy of the pool: free map (1 = free), slots taken and the registers
  logic [WORD_W-1:0]       free_map [MAP_WORDS];
  logic [COUNT_W-1:0]      slots_taken;
  logic [SLOT_CNT_W-1:0]   slot_count_q;
  logic [SLOT_BYTES_W-1:0] slot_bytes_q;
  logic [ADDR_W-1:0]       base_q;

  slot_result_t pending_q [$];
  int errors = 0;
  int checked = 0;

  assign mismatch_count_o = errors;
  assign checked_o        = checked;

  function automatic int unsigned usable_slots();
    return (slot_count_q > MAX_SLOTS) ? MAX_SLOTS : slot_count_q;
  endfunction

  function automatic void fill_map();
    int unsigned cap;
    int unsigned lo;
    cap = usable_slots();
    for (int w = 0; w < MAP_WORDS; w++) begin
      lo = w * WORD_W;
      if (cap >= lo + WORD_W) begin
        free_map[w] = '1;
      end else if (cap > lo) begin
        free_map[w] = (32'd1 << (cap - lo)) - 32'd1;
      end else begin
        free_map[w] = '0;
      end
    end
    slots_taken = '0;
  endfunction

  // Apply one request to the pool copy and return the response it must produce
  function automatic slot_result_t serve_request(logic [ACTION_W-1:0] act,
                                                 logic [ADDR_W-1:0] addr);
    slot_result_t r;
    int unsigned cap;
    int unsigned words;
    int unsigned slot;
    int w_hit;
    int b_hit;
    logic [ADDR_W-1:0] bytes_wide;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] index;
    cap = usable_slots();
    words = (cap + 31) / 32;
    bytes_wide = ADDR_W'(slot_bytes_q);
    r.slot_address = '0;
    r.status = ST_INIT;
    if (act == ACT_INIT) begin
      fill_map();
    end else if (act == ACT_ALLOC) begin
      r.status = ST_EXHAUSTED;
      w_hit = -1;
      for (int w = 0; w < MAP_WORDS; w++) begin
        if (w_hit < 0 && w < words && free_map[w] != '0) w_hit = w;
      end
      if (w_hit >= 0) begin
        b_hit = -1;
        for (int b = 0; b < WORD_W; b++) begin
          if (b_hit < 0 && free_map[w_hit][b]) b_hit = b;
        end
        slot = w_hit * WORD_W + b_hit;
        // a free bit past the slot count still means the pool is used up
        if (slot < cap) begin
          free_map[w_hit][b_hit] = 1'b0;
          if (slots_taken != COUNT_MAX) slots_taken = slots_taken + 1'b1;
          r.status = ST_ALLOC;
          r.slot_address = base_q + slot * bytes_wide;
        end
      end
    end else begin
      if (addr == '0) begin
        r.status = ST_NULL;
      end else if (slot_bytes_q == '0) begin
        r.status = ST_RANGE;
      end else begin
        offset = addr - base_q;
        index = offset / bytes_wide;
        if (index >= cap) begin
          r.status = ST_RANGE;
        end else if (offset != index * bytes_wide) begin
          r.status = ST_MISALIGN;
        end else if (free_map[index / WORD_W][index % WORD_W]) begin
          r.status = ST_DOUBLE;
        end else begin
          free_map[index / WORD_W][index % WORD_W] = 1'b1;
          if (slots_taken != '0) slots_taken = slots_taken - 1'b1;
          r.status = ST_FREED;
        end
      end
    end
    r.in_use = slots_taken;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t want;
    slot_result_t got;
    if (!rst_ni) begin
      slot_count_q = RST_SLOT_COUNT;
      slot_bytes_q = RST_SLOT_BYTES;
      base_q = RST_BASE;
      fill_map();
      pending_q.delete();
      awaiting_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLOT_COUNT:   slot_count_q = cfg_wdata_i[SLOT_CNT_W-1:0];
          CFG_SLOT_BYTES:   slot_bytes_q = cfg_wdata_i[SLOT_BYTES_W-1:0];
          CFG_BASE_ADDRESS: base_q = cfg_wdata_i[ADDR_W-1:0];
          default: ;
        endcase
      end
      // the unused action code is taken but answers nothing
      if (req_i.valid && req_i.ready &&
          (req_i.action == ACT_INIT || req_i.action == ACT_ALLOC ||
           req_i.action == ACT_FREE)) begin
        pending_q.push_back(serve_request(req_i.action, req_i.release_address));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        checked++;
        got.status = status_e'(rsp_i.status);
        got.slot_address = rsp_i.slot_address;
        got.in_use = rsp_i.in_use;
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: response without a request waiting: status %0d address %h in use %0d",
                   $time, got.status, got.slot_address, got.in_use);
        end else begin
          want = pending_q.pop_front();
          if (got.status !== want.status) errors++;
          if (got.slot_address !== want.slot_address) errors++;
          if (got.in_use !== want.in_use) errors++;
          if (got !== want) begin
            $display("%0t: expected status %0d address %h in use %0d, got status %0d address %h in use %0d",
                     $time, want.status, want.slot_address, want.in_use,
                     got.status, got.slot_address, got.in_use);
          end
        end
      end
      awaiting_o <= pending_q.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bsa_pkg::*;

  localparam int RESET_CYCLES    = 12;
  localparam int SWEEP_WAIT      = 30;
  localparam int SETTLE_CYCLES   = 48;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 75;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BEAT} sink_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bsa_req_if req_ch ();
  bsa_rsp_if rsp_ch ();

  int mismatches;
  int awaiting;
  int checked;
  int cycles = 0;

  int unsigned requests_sent = 0;
  int unsigned settings_used = 0;
  int unsigned allocs_since_init = 0;
  int unsigned cap_now;
  int unsigned burst_left;
  logic [SLOT_BYTES_W-1:0] bytes_now;
  logic [ADDR_W-1:0]       base_now;
  bit valid_up = 1'b0;

  sink_mode_e sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;
  int unsigned sink_period = 2;
  int unsigned sink_tick = 0;

  bitmap_slot_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  slot_alloc_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .req_i            (req_ch),
    .rsp_i            (rsp_ch),
    .mismatch_count_o (mismatches),
    .awaiting_o       (awaiting),
    .checked_o        (checked)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Response side: stall on a randomly chosen pattern that is redrawn when its run ends
  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(8, 120);
      sink_period = $urandom_range(2, 7);
    end
    sink_left--;
    sink_tick++;
    case (sink_mode)
      SINK_OPEN:   rsp_ch.ready <= 1'b1;
      SINK_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
      default:     rsp_ch.ready <= (sink_tick % sink_period == 0);
    endcase
  end

  function automatic logic [ADDR_W-1:0] slot_at(int unsigned idx);
    logic [ADDR_W-1:0] bytes_wide;
    bytes_wide = ADDR_W'(bytes_now);
    return base_now + idx * bytes_wide;
  endfunction

  // Hold the request until taken; idle between bursts
  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [ADDR_W-1:0] addr);
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.release_address <= addr;
    valid_up = 1'b1;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    if (act != ACT_NONE) requests_sent++;
    if (act == ACT_INIT) allocs_since_init = 0;
    if (act == ACT_ALLOC) allocs_since_init++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      req_ch.valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Drop valid, drain every expected response, then let a free run out
  task automatic settle();
    if (valid_up) begin
      req_ch.valid <= 1'b0;
      valid_up = 1'b0;
    end
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_pool(input logic [SLOT_CNT_W-1:0] count,
                              input logic [SLOT_BYTES_W-1:0] bytes,
                              input logic [ADDR_W-1:0] base);
    logic [CFG_DATA_W-1:0] noise;
    settle();
    // junk above the register width must be dropped
    noise = ($urandom_range(0, 1) != 0) ? $urandom : '0;
    cfg_we <= 1'b1;
    cfg_idx <= CFG_SLOT_COUNT;
    cfg_wdata <= {noise[CFG_DATA_W-1:SLOT_CNT_W], count};
    @(posedge clk_i);
    cfg_idx <= CFG_SLOT_BYTES;
    cfg_wdata <= {noise[CFG_DATA_W-1:SLOT_BYTES_W], bytes};
    @(posedge clk_i);
    cfg_idx <= CFG_BASE_ADDRESS;
    cfg_wdata <= base;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cap_now = (count > MAX_SLOTS) ? MAX_SLOTS : count;
    bytes_now = bytes;
    base_now = base;
    settings_used++;
  endtask

  // Mostly allocs and frees of slots likely in use, the rest bad addresses, inits and unused action codes
  task automatic random_request();
    int unsigned pick;
    int unsigned hi;
    int unsigned idx;
    hi = (allocs_since_init < cap_now) ? allocs_since_init : cap_now;
    idx = (hi > 0) ? $urandom_range(0, hi - 1) : 0;
    pick = $urandom_range(0, 99);
    if (pick < 44) begin
      send_request(ACT_ALLOC, $urandom);
    end else if (pick < 78) begin
      send_request(ACT_FREE, slot_at(idx));
    end else if (pick < 83) begin
      send_request(ACT_FREE, slot_at(idx) +
                   ((bytes_now > 1) ? $urandom_range(1, bytes_now - 1) : 1));
    end else if (pick < 88) begin
      send_request(ACT_FREE, slot_at(cap_now + $urandom_range(0, 3)));
    end else if (pick < 91) begin
      send_request(ACT_FREE, '0);
    end else if (pick < 96) begin
      send_request(ACT_FREE, $urandom);
    end else if (pick < 98) begin
      send_request(ACT_INIT, $urandom);
    end else begin
      send_request(ACT_NONE, $urandom);
    end
  endtask

  initial begin
    logic [SLOT_CNT_W-1:0]   count;
    logic [SLOT_BYTES_W-1:0] bytes;
    logic [ADDR_W-1:0]       base;
    int unsigned target;

    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_SLOT_COUNT;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_INIT;
    req_ch.release_address = '0;
    rsp_ch.ready = 1'b0;
    cap_now = MAX_SLOTS;
    bytes_now = RST_SLOT_BYTES;
    base_now = RST_BASE;
    burst_left = $urandom_range(1, 40);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    // map fill pass after reset
    repeat (SWEEP_WAIT) @(posedge clk_i);

    // Reset pool: slot zero sits at address zero, which still frees as null
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '1);
    send_request(ACT_FREE, 32'h0000_0000);
    send_request(ACT_FREE, 32'h0000_0010);
    send_request(ACT_FREE, 32'h0000_0010);
    send_request(ACT_FREE, 32'h0000_0021);
    send_request(ACT_FREE, 32'h0000_1000);
    send_request(ACT_FREE, 32'hFFFF_FFFF);
    send_request(ACT_NONE, 32'hFFFF_FFFF);

    // Empty pool
    program_pool(9'd0, 16'd8, 32'h0000_0100);
    send_request(ACT_INIT, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_FREE, 32'h0000_0100);

    // Count above the map, widest slot, addresses wrap past the top
    program_pool(9'd511, 16'hFFFF, 32'hFFFF_0000);
    send_request(ACT_INIT, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_FREE, 32'h0000_FFFE);
    send_request(ACT_FREE, 32'hFFFF_0001);

    // Zero slot size
    program_pool(9'd40, 16'd0, 32'h1234_5678);
    send_request(ACT_INIT, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_FREE, 32'h1234_5678);

    // Shrink without init: lowest free bit lies past the count
    program_pool(9'd1, 16'd4, 32'h0000_0040);
    send_request(ACT_ALLOC, '0);

    // Grow without init: free slots never mapped, count pins at zero
    program_pool(9'd200, 16'd4, 32'h0000_0040);
    send_request(ACT_FREE, 32'h0000_01D0);
    send_request(ACT_FREE, 32'h0000_01D4);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: count = SLOT_CNT_W'($urandom_range(1, 40));
        5:       count = SLOT_CNT_W'($urandom_range(41, 256));
        6:       count = 9'd256;
        7:       count = SLOT_CNT_W'($urandom_range(257, 511));
        8:       count = 9'd1;
        default: count = 9'd32;
      endcase
      case ($urandom_range(0, 7))
        0:       bytes = 16'd1;
        1:       bytes = 16'hFFFF;
        2:       bytes = 16'd1 << $urandom_range(0, 15);
        3:       bytes = 16'd0;
        default: bytes = SLOT_BYTES_W'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 3))
        0:       base = '0;
        1:       base = $urandom;
        2:       base = 32'hFFFF_FFFF - $urandom_range(0, 4096);
        default: base = $urandom & 32'hFFFF_F000;
      endcase
      program_pool(count, bytes, base);
      if ($urandom_range(0, 4) != 0) send_request(ACT_INIT, $urandom);
      target = requests_sent + ITEMS_PER_PHASE;
      while (requests_sent < target) random_request();
    end

    settle();
    $display("summary: %0d requests over %0d pool settings, %0d responses checked",
             requests_sent, settings_used, checked);
    $display("summary: empty, wrapped, zero-size and oversized pools, stale maps included");
    if (mismatches == 0 && awaiting == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
